FILE: rtl/core/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: rtl/core/tcme_pkg.sv
`default_nettype none
package tcme_pkg;

    localparam logic [2:0] FUNC_MOVE    = 3'd0;
    localparam logic [2:0] FUNC_HOME    = 3'd1;
    localparam logic [2:0] FUNC_CLEAR   = 3'd2;
    localparam logic [2:0] FUNC_ERASE_L = 3'd3;
    localparam logic [2:0] FUNC_ERASE_B = 3'd4;
    localparam logic [2:0] FUNC_SETPOS  = 3'd5;

    localparam logic [6:0] COORD_MAX = 7'd99;

    localparam logic [7:0] CH_CSI   = 8'd155;
    localparam logic [7:0] CH_BS    = 8'd8;
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_VT    = 8'd11;
    localparam logic [7:0] CH_FF    = 8'd12;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_ZERO  = 8'd48;
    localparam logic [7:0] CH_SEMI  = 8'd59;
    localparam logic [7:0] CH_B     = 8'd66;
    localparam logic [7:0] CH_C     = 8'd67;
    localparam logic [7:0] CH_H     = 8'd72;
    localparam logic [7:0] CH_J     = 8'd74;
    localparam logic [7:0] CH_K     = 8'd75;

    typedef enum logic [3:0] {
        K_CR,
        K_LF,
        K_VT,
        K_CSI_B,
        K_BS,
        K_CSI_C,
        K_FULL,
        K_HOME,
        K_CLEAR,
        K_EL,
        K_ED
    } kind_t;

    typedef struct packed {
        kind_t      kind;
        logic [3:0] row_tens;
        logic [3:0] row_ones;
        logic [3:0] col_tens;
        logic [3:0] col_ones;
    } desc_t;

    typedef struct packed {
        logic [7:0] value;
        logic       last;
    } seq_byte_t;

    function automatic logic [7:0] digit_char(input logic [3:0] d);
        return CH_ZERO + {4'd0, d};
    endfunction

    function automatic seq_byte_t seq_byte(input desc_t d, input logic [2:0] idx);
        seq_byte_t r;
        r.value = CH_CSI;
        r.last  = 1'b0;
        unique case (d.kind)
            K_CR:    begin r.value = CH_CR; r.last = 1'b1; end
            K_LF:    begin r.value = CH_LF; r.last = 1'b1; end
            K_VT:    begin r.value = CH_VT; r.last = 1'b1; end
            K_BS:    begin r.value = CH_BS; r.last = 1'b1; end
            K_CSI_B: begin r.value = (idx == 3'd0) ? CH_CSI : CH_B; r.last = (idx != 3'd0); end
            K_CSI_C: begin r.value = (idx == 3'd0) ? CH_CSI : CH_C; r.last = (idx != 3'd0); end
            K_HOME:  begin r.value = (idx == 3'd0) ? CH_CSI : CH_H; r.last = (idx != 3'd0); end
            K_EL:    begin r.value = (idx == 3'd0) ? CH_CSI : CH_K; r.last = (idx != 3'd0); end
            K_ED:    begin r.value = (idx == 3'd0) ? CH_CSI : CH_J; r.last = (idx != 3'd0); end
            K_CLEAR:
            begin
                unique case (idx)
                    3'd0:    r.value = CH_FF;
                    3'd1:    r.value = CH_CSI;
                    default: begin r.value = CH_H; r.last = 1'b1; end
                endcase
            end
            K_FULL:
            begin
                unique case (idx)
                    3'd0:    r.value = CH_CSI;
                    3'd1:    r.value = digit_char(d.row_tens);
                    3'd2:    r.value = digit_char(d.row_ones);
                    3'd3:    r.value = CH_SEMI;
                    3'd4:    r.value = digit_char(d.col_tens);
                    3'd5:    r.value = digit_char(d.col_ones);
                    default: begin r.value = CH_H; r.last = 1'b1; end
                endcase
            end
            default: begin r.value = CH_CSI; r.last = 1'b1; end
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/core/tcme_cmd_if.sv
`default_nettype none
interface tcme_cmd_if;
    logic       valid;
    logic       ready;
    logic [2:0] func;
    logic [6:0] col;
    logic [6:0] row;

    modport source (output valid, output func, output col, output row, input ready);
    modport sink (input valid, input func, input col, input row, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/tcme_byte_if.sv
`default_nettype none
interface tcme_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last;

    modport source (output valid, output out_byte, output last, input ready);
    modport sink (input valid, input out_byte, input last, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/tcme_front.sv
`default_nettype none
module tcme_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    tcme_cmd_if.sink           cmd,
    input  wire logic          q_full,
    output tcme_pkg::desc_t    push_desc,
    output logic               push
);
    import tcme_pkg::*;

    logic [6:0]  col_pos_reg, col_pos_next;
    logic [6:0]  row_pos_reg, row_pos_next;
    logic        known_reg, known_next;
    logic [6:0]  x, y;
    logic [14:0] x_prod, y_prod;
    logic [3:0]  x_tens, y_tens;
    logic [7:0]  x_w, y_w, cp_w, rp_w;
    logic        emit;
    kind_t       kind;
    logic        accept;

    assign cmd.ready = !q_full;
    assign accept    = cmd.valid && !q_full;

    assign x = (cmd.col > COORD_MAX) ? COORD_MAX : cmd.col;
    assign y = (cmd.row > COORD_MAX) ? COORD_MAX : cmd.row;

    // Division by ten through the reciprocal 205/2048, exact below 1029.
    assign x_prod = {8'd0, x} * 15'd205;
    assign y_prod = {8'd0, y} * 15'd205;
    assign x_tens = x_prod[14:11];
    assign y_tens = y_prod[14:11];

    assign x_w  = {1'b0, x};
    assign y_w  = {1'b0, y};
    assign cp_w = {1'b0, col_pos_reg};
    assign rp_w = {1'b0, row_pos_reg};

    always_comb
    begin
        emit         = 1'b0;
        kind         = K_FULL;
        col_pos_next = col_pos_reg;
        row_pos_next = row_pos_reg;
        known_next   = known_reg;
        unique case (cmd.func)
            FUNC_MOVE:
            begin
                emit         = 1'b1;
                col_pos_next = x;
                row_pos_next = y;
                known_next   = 1'b1;
                if (known_reg)
                begin
                    if (x_w == cp_w && y_w == rp_w)
                    begin
                        emit = 1'b0;
                    end
                    else if (x_w == 8'd1)
                    begin
                        if (y_w == rp_w)
                            kind = K_CR;
                        else if (y_w == rp_w + 8'd1)
                            kind = K_LF;
                    end
                    else if (x_w == cp_w)
                    begin
                        if (y_w + 8'd1 == rp_w)
                            kind = K_VT;
                        else if (y_w == rp_w + 8'd1)
                            kind = K_CSI_B;
                    end
                    else if (y_w == rp_w)
                    begin
                        if (x_w + 8'd1 == cp_w)
                            kind = K_BS;
                        else if (x_w == cp_w + 8'd1)
                            kind = K_CSI_C;
                    end
                end
            end
            FUNC_HOME:
            begin
                emit         = 1'b1;
                kind         = K_HOME;
                col_pos_next = 7'd1;
                row_pos_next = 7'd1;
                known_next   = 1'b1;
            end
            FUNC_CLEAR:
            begin
                emit         = 1'b1;
                kind         = K_CLEAR;
                col_pos_next = 7'd1;
                row_pos_next = 7'd1;
                known_next   = 1'b1;
            end
            FUNC_ERASE_L:
            begin
                emit = 1'b1;
                kind = K_EL;
            end
            FUNC_ERASE_B:
            begin
                emit = 1'b1;
                kind = K_ED;
            end
            FUNC_SETPOS:
            begin
                col_pos_next = x;
                row_pos_next = y;
                known_next   = 1'b1;
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
    end

    assign push               = accept && emit;
    assign push_desc.kind     = kind;
    assign push_desc.row_tens = y_tens;
    assign push_desc.row_ones = 4'(y - 7'(y_tens) * 7'd10);
    assign push_desc.col_tens = x_tens;
    assign push_desc.col_ones = 4'(x - 7'(x_tens) * 7'd10);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_pos_reg <= 7'd0;
            row_pos_reg <= 7'd0;
            known_reg   <= 1'b0;
        end
        else if (accept)
        begin
            col_pos_reg <= col_pos_next;
            row_pos_reg <= row_pos_next;
            known_reg   <= known_next;
        end
    end
endmodule
`default_nettype wire

FILE: rtl/core/tcme_queue.sv
`default_nettype none
module tcme_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire tcme_pkg::desc_t  push_desc,
    output logic                  full,
    input  wire logic             pop,
    output logic                  q_valid,
    output tcme_pkg::desc_t       q_desc
);
    import tcme_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    desc_t           mem_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]   count_reg;
    logic            do_push, do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_desc  = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && q_valid;

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_desc;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
            if (do_push && !do_pop)
                count_reg <= count_reg + CW'(1);
            else if (do_pop && !do_push)
                count_reg <= count_reg - CW'(1);
        end
    end
endmodule
`default_nettype wire

FILE: rtl/core/tcme_back.sv
`default_nettype none
module tcme_back (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             q_valid,
    input  wire tcme_pkg::desc_t  q_desc,
    output logic                  pop,
    tcme_byte_if.source           res
);
    import tcme_pkg::*;

    desc_t      cur_reg, cur_next;
    logic       cur_valid_reg, cur_valid_next;
    logic [2:0] idx_reg, idx_next;
    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_byte_reg, out_byte_next;
    logic       last_reg, last_next;
    seq_byte_t  sb;
    logic       load;

    assign sb   = seq_byte(cur_reg, idx_reg);
    assign load = !out_valid_reg || res.ready;
    assign pop  = q_valid && (!cur_valid_reg || (load && sb.last));

    always_comb
    begin
        cur_next       = cur_reg;
        cur_valid_next = cur_valid_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        last_next      = last_reg;
        if (load)
        begin
            out_valid_next = cur_valid_reg;
            if (cur_valid_reg)
            begin
                out_byte_next = sb.value;
                last_next     = sb.last;
                idx_next      = idx_reg + 3'd1;
                if (sb.last)
                    cur_valid_next = 1'b0;
            end
        end
        if (pop)
        begin
            cur_next       = q_desc;
            cur_valid_next = 1'b1;
            idx_next       = 3'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= 3'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg      <= cur_next;
        out_byte_reg <= out_byte_next;
        last_reg     <= last_next;
    end

    assign res.valid    = out_valid_reg;
    assign res.out_byte = out_byte_reg;
    assign res.last     = last_reg;
endmodule
`default_nettype wire

FILE: rtl/core/terminal_cursor_motion_encoder.sv
// Channel  Direction  Payload               Request
// cmd      in         func, col, row        one terminal command
// res      out        out_byte, last        one console byte
//
// A command is taken whenever the command queue has room; it holds QUEUE_DEPTH
// entries. The byte engine sends one byte a cycle while res is ready; a command
// has one to seven bytes, and silent commands never reach the byte engine.
// Reset clears the queue, the byte engine and the res valid flag, and leaves the
// cursor position unknown. A stall on res fills the queue and then drops cmd.ready.
`default_nettype none
module terminal_cursor_motion_encoder #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    tcme_cmd_if.sink      cmd,
    tcme_byte_if.source   res
);
    import tcme_pkg::*;

    desc_t push_desc;
    desc_t q_desc;
    logic  push;
    logic  q_full;
    logic  q_valid;
    logic  pop;

    tcme_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .q_full    (q_full),
        .push_desc (push_desc),
        .push      (push)
    );

    tcme_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_desc (push_desc),
        .full      (q_full),
        .pop       (pop),
        .q_valid   (q_valid),
        .q_desc    (q_desc)
    );

    tcme_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_desc  (q_desc),
        .pop     (pop),
        .res     (res)
    );
endmodule
`default_nettype wire

FILE: rtl/core/tcme_checker.sv
`default_nettype none
`include "assert_macros.svh"
module tcme_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       res_valid,
    input wire logic       res_ready,
    input wire logic [7:0] out_byte,
    input wire logic       last
);
    import tcme_pkg::*;

    logic lead_byte;
    logic closing_byte;
    logic trailer_byte;

    assign lead_byte    = out_byte == CH_CSI || out_byte == CH_FF || out_byte == CH_SEMI
                          || (out_byte >= CH_ZERO && out_byte <= CH_ZERO + 8'd9);
    assign closing_byte = out_byte == CH_CR || out_byte == CH_LF || out_byte == CH_VT
                          || out_byte == CH_BS || out_byte == CH_B || out_byte == CH_C
                          || out_byte == CH_H || out_byte == CH_J || out_byte == CH_K;
    assign trailer_byte = out_byte == CH_SEMI || out_byte == CH_H || out_byte == CH_J
                          || out_byte == CH_K || out_byte == CH_B || out_byte == CH_C;

    // A lead-in byte, a digit, the separator or a form feed is always followed by more.
    `ASSERT_IMPLY(a_csi_not_last, clk, rst_n, res_valid && lead_byte, !last)

    // Control characters and final letters always close a sequence.
    `ASSERT_IMPLY(a_final_is_last, clk, rst_n, res_valid && closing_byte, last)

    // The first byte after a finished sequence begins a new one.
    `ASSERT_NEXT(a_new_seq_start, clk, rst_n, res_valid && res_ready && last, !res_valid || !trailer_byte)

    // A stalled byte stays on the port unchanged.
    `ASSERT_NEXT(a_stall_hold, clk, rst_n, res_valid && !res_ready, res_valid && $stable(out_byte) && $stable(last))
endmodule

bind terminal_cursor_motion_encoder tcme_checker u_tcme_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res.valid),
    .res_ready (res.ready),
    .out_byte  (res.out_byte),
    .last      (res.last)
);
`default_nettype wire

FILE: tb/sv/terminal_cursor_motion_encoder_checker.sv
module terminal_cursor_motion_encoder_checker
    import tcme_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    tcme_cmd_if  cmd,
    tcme_byte_if res,
    output int   failures,
    output int   pending,
    output int   bytes_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [6:0] cursor_col = 7'd0;
    logic [6:0] cursor_row = 7'd0;
    logic       cursor_known = 1'b0;
    seq_byte_t  owed_bytes[$];
    int         mismatch_count = 0;
    int         byte_count = 0;
    int         owed_count = 0;

    assign failures      = mismatch_count;
    assign pending       = owed_count;
    assign bytes_checked = byte_count;

    // Works out the console bytes for one command and moves the tracked cursor.
    function automatic void predict_command(input logic [2:0] func, input logic [6:0] col,
                                            input logic [6:0] row);
        int         x;
        int         y;
        int         cx;
        int         cy;
        int         k;
        logic [7:0] seq[$];
        seq_byte_t  b;
        x  = (col > COORD_MAX) ? int'(COORD_MAX) : int'(col);
        y  = (row > COORD_MAX) ? int'(COORD_MAX) : int'(row);
        cx = int'(cursor_col);
        cy = int'(cursor_row);
        case (func)
            FUNC_MOVE:
            begin
                if (!(cursor_known && x == cx && y == cy))
                begin
                    if (cursor_known && x == 1)
                    begin
                        if (y == cy)
                            seq.push_back(CH_CR);
                        else if (y == cy + 1)
                            seq.push_back(CH_LF);
                    end
                    else if (cursor_known && x == cx)
                    begin
                        if (y + 1 == cy)
                            seq.push_back(CH_VT);
                        else if (y == cy + 1)
                        begin
                            seq.push_back(CH_CSI);
                            seq.push_back(CH_B);
                        end
                    end
                    else if (cursor_known && y == cy)
                    begin
                        if (x + 1 == cx)
                            seq.push_back(CH_BS);
                        else if (x == cx + 1)
                        begin
                            seq.push_back(CH_CSI);
                            seq.push_back(CH_C);
                        end
                    end
                    if (seq.size() == 0)
                    begin
                        seq.push_back(CH_CSI);
                        seq.push_back(CH_ZERO + 8'(y / 10));
                        seq.push_back(CH_ZERO + 8'(y % 10));
                        seq.push_back(CH_SEMI);
                        seq.push_back(CH_ZERO + 8'(x / 10));
                        seq.push_back(CH_ZERO + 8'(x % 10));
                        seq.push_back(CH_H);
                    end
                end
                cursor_col   = 7'(x);
                cursor_row   = 7'(y);
                cursor_known = 1'b1;
            end
            FUNC_HOME:
            begin
                seq.push_back(CH_CSI);
                seq.push_back(CH_H);
                cursor_col   = 7'd1;
                cursor_row   = 7'd1;
                cursor_known = 1'b1;
            end
            FUNC_CLEAR:
            begin
                seq.push_back(CH_FF);
                seq.push_back(CH_CSI);
                seq.push_back(CH_H);
                cursor_col   = 7'd1;
                cursor_row   = 7'd1;
                cursor_known = 1'b1;
            end
            FUNC_ERASE_L:
            begin
                seq.push_back(CH_CSI);
                seq.push_back(CH_K);
            end
            FUNC_ERASE_B:
            begin
                seq.push_back(CH_CSI);
                seq.push_back(CH_J);
            end
            FUNC_SETPOS:
            begin
                cursor_col   = 7'(x);
                cursor_row   = 7'(y);
                cursor_known = 1'b1;
            end
            default:
            begin
            end
        endcase
        for (k = 0; k < seq.size(); k++)
        begin
            b.value = seq[k];
            b.last  = (k == seq.size() - 1);
            owed_bytes.push_back(b);
        end
    endfunction

    always @(posedge clk)
    begin
        seq_byte_t want;
        if (rst_n)
        begin
            if (res.valid && res.ready)
            begin
                byte_count++;
                if (owed_bytes.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("Unrequested byte %0d (last %0b) at %0t.",
                                 res.out_byte, res.last, $realtime);
                end
                else
                begin
                    want = owed_bytes.pop_front();
                    if (want.value !== res.out_byte || want.last !== res.last)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("Byte %0d wrong: expected %0d last %0b, got %0d last %0b.",
                                     byte_count, want.value, want.last, res.out_byte, res.last);
                    end
                end
            end
            if (cmd.valid && cmd.ready)
                predict_command(cmd.func, cmd.col, cmd.row);
            owed_count = owed_bytes.size();
        end
    end

endmodule

FILE: tb/sv/terminal_cursor_motion_encoder_test.sv
module terminal_cursor_motion_encoder_test;
    timeunit 1ns;
    timeprecision 1ps;

    import tcme_pkg::*;

    localparam logic [2:0] FUNC_SPARE_LO = 3'd6;
    localparam logic [2:0] FUNC_SPARE_HI = 3'd7;
    localparam int RANDOM_ITEMS = 320;
    localparam int TAIL_CYCLES  = 32;
    localparam int CYCLE_LIMIT  = 200000;

    logic clk = 1'b0;
    logic rst_n;
    int   failures;
    int   pending;
    int   bytes_checked;
    int   sender_idle_pct = 36;
    int   sink_idle_pct = 67;
    int   command_count = 0;
    int   ignored_count = 0;
    int   cycle_count = 0;
    int   aim_col = 0;
    int   aim_row = 0;

    tcme_cmd_if  cmd();
    tcme_byte_if res();

    terminal_cursor_motion_encoder dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .res   (res)
    );

    terminal_cursor_motion_encoder_checker checker_inst
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .res           (res),
        .failures      (failures),
        .pending       (pending),
        .bytes_checked (bytes_checked)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Run stopped after %0d cycles with %0d bytes outstanding.",
                     cycle_count, pending);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial
    begin
        res.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            res.ready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    task automatic send_command(input logic [2:0] f, input logic [6:0] c, input logic [6:0] r);
        int gap;
        gap = 0;
        while (gap < 12 && $urandom_range(99) < sender_idle_pct)
            gap++;
        if (gap > 0)
        begin
            cmd.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd.valid <= 1'b1;
        cmd.func  <= f;
        cmd.col   <= c;
        cmd.row   <= r;
        @(posedge clk);
        while (!cmd.ready)
            @(posedge clk);
        if (f > FUNC_SETPOS)
            ignored_count++;
        else
            command_count++;
        // Keep a rough idea of the cursor so that random moves land close to it.
        if (f == FUNC_MOVE || f == FUNC_SETPOS)
        begin
            aim_col = (c > COORD_MAX) ? int'(COORD_MAX) : int'(c);
            aim_row = (r > COORD_MAX) ? int'(COORD_MAX) : int'(r);
        end
        else if (f == FUNC_HOME || f == FUNC_CLEAR)
        begin
            aim_col = 1;
            aim_row = 1;
        end
    endtask

    function automatic logic [6:0] nudge(input int base);
        int v;
        v = base + int'($urandom_range(2)) - 1;
        if (v < 0)
            v = 0;
        return 7'(v);
    endfunction

    task automatic random_command();
        int         pick;
        logic [2:0] f;
        logic [6:0] c;
        logic [6:0] r;
        pick = $urandom_range(99);
        f    = FUNC_MOVE;
        c    = 7'($urandom_range(127));
        r    = 7'($urandom_range(127));
        if (pick < 45)
        begin
            c = ($urandom_range(3) == 0) ? 7'd1 : nudge(aim_col);
            r = nudge(aim_row);
        end
        else if (pick < 60)
            f = FUNC_MOVE;
        else if (pick < 68)
            f = FUNC_SETPOS;
        else if (pick < 74)
            f = FUNC_HOME;
        else if (pick < 80)
            f = FUNC_CLEAR;
        else if (pick < 86)
            f = FUNC_ERASE_L;
        else if (pick < 92)
            f = FUNC_ERASE_B;
        else if (pick < 97)
            f = 3'($urandom_range(7));
        else
            f = 3'($urandom_range(FUNC_SPARE_HI, FUNC_SPARE_LO));
        send_command(f, c, r);
    endtask

    initial
    begin
        int base;
        rst_n     <= 1'b0;
        cmd.valid <= 1'b0;
        cmd.func  <= FUNC_MOVE;
        cmd.col   <= 7'd0;
        cmd.row   <= 7'd0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // The first move after reset has no known position and must use the full form.
        send_command(FUNC_MOVE, 7'd5, 7'd7);
        send_command(FUNC_MOVE, 7'd5, 7'd7);
        send_command(FUNC_MOVE, 7'd1, 7'd7);
        send_command(FUNC_MOVE, 7'd1, 7'd8);
        send_command(FUNC_MOVE, 7'd1, 7'd7);
        send_command(FUNC_SETPOS, 7'd20, 7'd20);
        send_command(FUNC_MOVE, 7'd20, 7'd19);
        send_command(FUNC_MOVE, 7'd20, 7'd20);
        send_command(FUNC_MOVE, 7'd19, 7'd20);
        send_command(FUNC_MOVE, 7'd20, 7'd20);
        send_command(FUNC_MOVE, 7'd0, 7'd0);
        send_command(FUNC_MOVE, 7'd127, 7'd127);
        send_command(FUNC_MOVE, 7'd99, 7'd99);
        send_command(FUNC_SETPOS, 7'd127, 7'd0);
        send_command(FUNC_MOVE, 7'd98, 7'd0);
        send_command(FUNC_ERASE_L, 7'd0, 7'd0);
        send_command(FUNC_ERASE_B, 7'd127, 7'd127);
        send_command(FUNC_SPARE_LO, 7'd3, 7'd3);
        send_command(FUNC_SPARE_HI, 7'd127, 7'd127);
        send_command(FUNC_HOME, 7'd127, 7'd127);
        send_command(FUNC_MOVE, 7'd1, 7'd1);
        send_command(FUNC_CLEAR, 7'd0, 7'd0);
        send_command(FUNC_MOVE, 7'd2, 7'd1);
        send_command(FUNC_MOVE, 7'd2, 7'd2);

        base = command_count;
        while (command_count - base < RANDOM_ITEMS)
        begin
            if (command_count - base == RANDOM_ITEMS / 3)
            begin
                sender_idle_pct = 67;
                sink_idle_pct   = 36;
            end
            else if (command_count - base == 2 * RANDOM_ITEMS / 3)
            begin
                sender_idle_pct = 0;
                sink_idle_pct   = 0;
            end
            random_command();
        end

        cmd.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Sent %0d terminal commands and %0d unused codes over three idling phases.",
                 command_count, ignored_count);
        $display("Compared %0d console bytes; %0d mismatches, %0d bytes still owed.",
                 bytes_checked, failures, pending);
        if (failures == 0 && pending == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
